// ----- rtl/core/mbfp_pkg.sv -----
// Shared types and constants for the motor bus fault protector.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbfp_pkg;

    // Fault codes held in the latched fault register
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_VOLT = 2'd1;
    localparam logic [1:0] FAULT_CURR = 2'd2;

    // Configuration register indexes
    localparam int         CFG_ADDR_BITS   = 3;
    localparam logic [2:0] CFG_MIN_VOLTAGE = 3'd0;
    localparam logic [2:0] CFG_MAX_VOLTAGE = 3'd1;
    localparam logic [2:0] CFG_MAX_CURRENT = 3'd2;
    localparam logic [2:0] CFG_TRIP_TICKS  = 3'd3;
    localparam logic [2:0] CFG_RECOV_TICKS = 3'd4;

    // Tick threshold registers are fixed at 16 bits
    localparam int          TICK_BITS      = 16;
    localparam logic [15:0] TICKS_RESET    = 16'd1000;
    localparam logic [31:0] SAMPLE_FULL    = 32'd4095;

    // Result word: stop, restart, fault code, then zero fill to a byte
    localparam int OUT_W = 8;

    typedef struct packed {
        logic [1:0] fault_code;
        logic       restart_request;
        logic       stop_request;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/mbfp_tick_logic.sv -----
// Per-tick protection logic: window and limit checks, trip and recovery counters.
// Depends on mbfp_pkg.
`default_nettype none

module mbfp_tick_logic
    import mbfp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic [SAMPLE_BITS-1:0] i_bus_voltage,
    input  wire logic [SAMPLE_BITS-1:0] i_bus_amps,
    input  wire logic                   i_motor_stopped,
    input  wire logic [SAMPLE_BITS-1:0] i_min_voltage,
    input  wire logic [SAMPLE_BITS-1:0] i_max_voltage,
    input  wire logic [SAMPLE_BITS-1:0] i_max_current,
    input  wire logic [TICK_BITS-1:0]   i_trip_ticks,
    input  wire logic [TICK_BITS-1:0]   i_recov_ticks,
    input  wire logic [COUNT_BITS-1:0]  i_voltage_count,
    input  wire logic [COUNT_BITS-1:0]  i_current_count,
    input  wire logic [COUNT_BITS-1:0]  i_recovery_count,
    input  wire logic [1:0]             i_fault,
    output logic [COUNT_BITS-1:0]       o_voltage_count,
    output logic [COUNT_BITS-1:0]       o_current_count,
    output logic [COUNT_BITS-1:0]       o_recovery_count,
    output logic [1:0]                  o_fault,
    output t_result                     o_result
);

    localparam int CmpW = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;

    logic [COUNT_BITS-1:0] v_inc, c_inc, r_inc_cnt;
    logic                  v_hit, c_hit, r_hit;
    logic                  v_out, c_out;
    logic [1:0]            fault_mid;
    logic                  stop_req, restart_req;

    always_comb begin
        v_inc     = i_voltage_count + COUNT_BITS'(1);
        c_inc     = i_current_count + COUNT_BITS'(1);
        r_inc_cnt = i_recovery_count + COUNT_BITS'(1);
        v_hit     = CmpW'(v_inc) >= CmpW'(i_trip_ticks);
        c_hit     = CmpW'(c_inc) >= CmpW'(i_trip_ticks);
        r_hit     = CmpW'(r_inc_cnt) >= CmpW'(i_recov_ticks);
        v_out     = (i_bus_voltage < i_min_voltage) || (i_bus_voltage > i_max_voltage);
        c_out     = i_bus_amps > i_max_current;

        stop_req    = 1'b0;
        restart_req = 1'b0;
        fault_mid   = i_fault;

        // voltage window first
        o_voltage_count = '0;
        if (v_out) begin
            if (v_hit) begin
                fault_mid = FAULT_VOLT;
                stop_req  = 1'b1;
            end else begin
                o_voltage_count = v_inc;
            end
        end

        // over-current second, so it wins a same-tick trip
        o_current_count = '0;
        if (c_out) begin
            if (c_hit) begin
                fault_mid = FAULT_CURR;
                stop_req  = 1'b1;
            end else begin
                o_current_count = c_inc;
            end
        end

        // recovery runs only while stopped (a trip counts as stopped)
        o_fault          = fault_mid;
        o_recovery_count = i_recovery_count;
        if (i_motor_stopped || stop_req) begin
            if (fault_mid != FAULT_NONE) begin
                if (r_hit) begin
                    o_recovery_count = '0;
                    o_fault          = FAULT_NONE;
                    restart_req      = 1'b1;
                end else begin
                    o_recovery_count = r_inc_cnt;
                end
            end else begin
                o_recovery_count = '0;
            end
        end

        o_result.stop_request    = stop_req;
        o_result.restart_request = restart_req;
        o_result.fault_code      = o_fault;
    end

endmodule

`default_nettype wire

// ----- rtl/core/motor_bus_fault_protector_core.sv -----
// An accepted input word is held in the input register, then its result in the result
// register, which drives the master side; a master-side stall can hold either stage.
// Throughput: one word per cycle while the master side keeps up; the input register
// feeds the result register through one pass of compare and counter logic.
// Reset (i_rst_n low, synchronous): both stages empty, counters and latched fault
// cleared, thresholds back to their defaults (window 0..full scale, 1000 ticks).
// Top level of the motor bus fault protector. Depends on mbfp_pkg, mbfp_tick_logic.
`default_nettype none

module motor_bus_fault_protector_core
    import mbfp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16,
    localparam int InW  = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8,
    localparam int CfgW = (SAMPLE_BITS > TICK_BITS) ? SAMPLE_BITS : TICK_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // slave side: one control tick per word
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // tdata from bit 0: bus_voltage, bus_amps, motor_stopped, zero fill
    input  wire logic [InW-1:0]           i_s_tdata,
    // master side: one result word per tick
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // tdata from bit 0: stop_request, restart_request, fault_code[1:0], zero fill
    output logic [OUT_W-1:0]              o_m_tdata,
    // configuration write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CfgW-1:0]          i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_min_voltage, r_max_voltage, r_max_current;
    logic [TICK_BITS-1:0]   r_trip_ticks, r_recov_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_voltage <= '0;
            r_max_voltage <= SAMPLE_BITS'(SAMPLE_FULL);
            r_max_current <= SAMPLE_BITS'(SAMPLE_FULL);
            r_trip_ticks  <= TICKS_RESET;
            r_recov_ticks <= TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_VOLTAGE: r_min_voltage <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_MAX_VOLTAGE: r_max_voltage <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_MAX_CURRENT: r_max_current <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_TRIP_TICKS:  r_trip_ticks  <= i_cfg_data[TICK_BITS-1:0];
                CFG_RECOV_TICKS: r_recov_ticks <= i_cfg_data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Two-stage flow control. The result stage loads whenever it is empty
    // or being drained, so the input stage takes a word every cycle while
    // the master side keeps up. A waiting result stops the result stage;
    // the input stage then takes one more word and holds it.
    // ---------------------------------------------------------------
    logic r_in_valid, r_out_valid;
    logic out_load, s_fire, advance;

    assign out_load   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || out_load;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign advance    = r_in_valid && out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= advance;
            end
        end
    end

    // Input register (payload only)
    logic [SAMPLE_BITS-1:0] r_bus_voltage, r_bus_amps;
    logic                   r_motor_stopped;

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_bus_voltage   <= i_s_tdata[SAMPLE_BITS-1:0];
            r_bus_amps      <= i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_motor_stopped <= i_s_tdata[2*SAMPLE_BITS];
        end
    end

    // ---------------------------------------------------------------
    // Protection state and per-tick logic
    // ---------------------------------------------------------------
    logic [COUNT_BITS-1:0] r_voltage_count, r_current_count, r_recovery_count;
    logic [1:0]            r_fault;
    logic [COUNT_BITS-1:0] n_voltage_count, n_current_count, n_recovery_count;
    logic [1:0]            n_fault;
    t_result               n_result;
    t_result               r_result;

    mbfp_tick_logic #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_tick (
        .i_bus_voltage    (r_bus_voltage),
        .i_bus_amps       (r_bus_amps),
        .i_motor_stopped  (r_motor_stopped),
        .i_min_voltage    (r_min_voltage),
        .i_max_voltage    (r_max_voltage),
        .i_max_current    (r_max_current),
        .i_trip_ticks     (r_trip_ticks),
        .i_recov_ticks    (r_recov_ticks),
        .i_voltage_count  (r_voltage_count),
        .i_current_count  (r_current_count),
        .i_recovery_count (r_recovery_count),
        .i_fault          (r_fault),
        .o_voltage_count  (n_voltage_count),
        .o_current_count  (n_current_count),
        .o_recovery_count (n_recovery_count),
        .o_fault          (n_fault),
        .o_result         (n_result)
    );

    // State moves only when a tick passes into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_count  <= '0;
            r_current_count  <= '0;
            r_recovery_count <= '0;
            r_fault          <= FAULT_NONE;
        end else if (advance) begin
            r_voltage_count  <= n_voltage_count;
            r_current_count  <= n_current_count;
            r_recovery_count <= n_recovery_count;
            r_fault          <= n_fault;
        end
    end

    // Result register (payload only)
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_W - 4)'(0), r_result.fault_code,
                         r_result.restart_request, r_result.stop_request};

endmodule

`default_nettype wire

// ----- rtl/core/mbfp_checker.sv -----
// Port-level checks for the motor bus fault protector, bound to the top level.
// Depends on mbfp_pkg and motor_bus_fault_protector_core.
`default_nettype none

module mbfp_checker
    import mbfp_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);

    // a restart always clears the fault in the same word
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> (o_m_tdata[3:2] == FAULT_NONE))
        else $error("restart word with fault still latched");

    // a trip without restart leaves a fault latched
    a_trip_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0] && !o_m_tdata[1]) |-> (o_m_tdata[3:2] != FAULT_NONE))
        else $error("stop request without latched fault");

    // only defined fault codes and zero fill reach the port
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[3:2] == FAULT_NONE || o_m_tdata[3:2] == FAULT_VOLT ||
                         o_m_tdata[3:2] == FAULT_CURR) && o_m_tdata[OUT_W-1:4] == '0))
        else $error("bad fault code or fill bits");

    // stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed under stall");

endmodule

bind motor_bus_fault_protector_core mbfp_checker u_mbfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
